[hdl/hcmf_pkg.sv]
// Shared codes and types of the header checked message framer.
`timescale 1ns / 1ps

package hcmf_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HELD    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_LAST    = 2'd2;
  localparam logic [1:0] KIND_DISCARD = 2'd3;

  // Rejection codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_SYMBOL     = 3'd1;
  localparam logic [2:0] ERR_OFS_SMALL  = 3'd2;
  localparam logic [2:0] ERR_OFS_BEYOND = 3'd3;
  localparam logic [2:0] ERR_CHECKSUM   = 3'd4;
  localparam logic [2:0] ERR_SHORT      = 3'd5;

  localparam logic [15:0] MAGIC_RESET = 16'h1111;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  kind;
    logic [31:0] message_type;
    logic [2:0]  error_code;
  } result_t;

endpackage

[hdl/header_checked_message_framer.sv]
// Top level of the header checked message framer: input beat register and result register.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake                    | Contents
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata = data_byte, tlast = buffer_end
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata = byte_out, message_type,
//          |     |                              |   error_code; tuser = kind
// cfg      | in  | cfg_we_i                     | cfg_wdata_i = magic_symbol
//
// One beat per cycle sustained while m_axis is not stalled; a beat passes from the input
// register through the framing logic into the result register, which presents it on m_axis.
// The input register feeds the framing logic, which loads the result register directly.
// A stall on m_axis holds the result and lets one more input beat wait in the input register.
// Reset clears all framing state and loads magic_symbol with 0x1111; no clearing pass.

module header_checked_message_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // buffer_end
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [hcmf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
                                      // [7:0] byte_out, [39:8] message_type,
                                      // [42:40] error_code, [47:43] zero
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_end_q;
  logic              out_valid_q;
  hcmf_pkg::result_t out_q;
  hcmf_pkg::result_t res;
  logic              advance;
  logic              s_accept;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  hcmf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .end_i       (in_end_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_q.error_code, out_q.message_type, out_q.byte_out};
  assign m_axis_tuser  = out_q.kind;

  a_type_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind != hcmf_pkg::KIND_LAST)) |-> (out_q.message_type == 32'h0))
    else $error("message_type set on a beat that does not close a message");

  a_err_only_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.error_code != hcmf_pkg::ERR_NONE))
      |-> (out_q.kind == hcmf_pkg::KIND_DISCARD))
    else $error("error code on a beat that is not discarded");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while a stage is free");

  a_advance_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed beat missing from result register");

endmodule

[hdl/hcmf_csum.sv]
// Ones' complement checksum step: byte pairing, end-around fold and match.
`timescale 1ns / 1ps

module hcmf_csum (
  input  logic [15:0] sum_i,
  input  logic [7:0]  pend_i,
  input  logic [7:0]  byte_i,
  input  logic        odd_i,
  input  logic        zero_i,
  input  logic [15:0] stored_i,
  output logic [15:0] sum_o,
  output logic [7:0]  pend_o,
  output logic        match_o
);

  logic [7:0]  byte_z;
  logic [15:0] addend;
  logic [16:0] raw;
  logic [15:0] folded;

  // Checksum field bytes count as zero
  assign byte_z = zero_i ? 8'h00 : byte_i;

  // Odd byte completes a word; even byte is checked as a trailing low byte
  assign addend = odd_i ? {byte_z, pend_i} : {8'h00, byte_z};
  assign raw    = {1'b0, sum_i} + {1'b0, addend};
  assign folded = raw[15:0] + {15'h0000, raw[16]};

  assign sum_o   = odd_i ? folded : sum_i;
  assign pend_o  = odd_i ? pend_i : byte_z;
  assign match_o = (~folded) == stored_i;

endmodule

[hdl/hcmf_core.sv]
// Framing state machine: header capture, checks, payload count and discard.
`timescale 1ns / 1ps

module hcmf_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                end_i,
  output hcmf_pkg::result_t   res_o
);

  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_EXTENDED = 2'd1;
  localparam logic [1:0] PH_PAYLOAD  = 2'd2;
  localparam logic [1:0] PH_DISCARD  = 2'd3;

  localparam logic [31:0] POS_SYM_HI = 32'd9;
  localparam logic [31:0] POS_CHK_LO = 32'd16;
  localparam logic [31:0] POS_CHK_HI = 32'd17;
  localparam logic [31:0] POS_OFS_LO = 32'd18;
  localparam logic [31:0] POS_OFS_HI = 32'd19;
  localparam logic [31:0] POS_TYPE_END = 32'd4;
  localparam logic [31:0] POS_LEN_END  = 32'd8;
  localparam logic [15:0] HDR_BYTES  = 16'd20;

  logic [31:0] pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  pend_q, pend_d;
  logic [31:0] len_q, len_d;
  logic [15:0] ofs_q, ofs_d;
  logic [15:0] chk_q, chk_d;
  logic [31:0] type_q, type_d;
  logic [1:0]  phase_q, phase_d;
  logic        sym_bad_q, sym_bad_d;
  logic [15:0] magic_q;

  logic [31:0] pos_inc;
  logic [15:0] cs_sum;
  logic [7:0]  cs_pend;
  logic        cs_match;
  logic        restart;
  logic [1:0]  kind;
  logic [2:0]  err;

  assign pos_inc = pos_q + 32'd1;

  hcmf_csum u_csum (
    .sum_i    (sum_q),
    .pend_i   (pend_q),
    .byte_i   (byte_i),
    .odd_i    (pos_q[0]),
    .zero_i   ((pos_q == POS_CHK_LO) || (pos_q == POS_CHK_HI)),
    .stored_i (chk_q),
    .sum_o    (cs_sum),
    .pend_o   (cs_pend),
    .match_o  (cs_match)
  );

  always_comb begin
    pos_d     = pos_q;
    sum_d     = sum_q;
    pend_d    = pend_q;
    len_d     = len_q;
    ofs_d     = ofs_q;
    chk_d     = chk_q;
    type_d    = type_q;
    phase_d   = phase_q;
    sym_bad_d = sym_bad_q;
    restart   = 1'b0;
    kind      = hcmf_pkg::KIND_HELD;
    err       = hcmf_pkg::ERR_NONE;

    case (phase_q)
      PH_HEADER: begin
        if (pos_q < POS_TYPE_END) begin
          if (pos_q[1:0] == 2'd0) begin
            type_d = 32'h0;
          end
          type_d[{pos_q[1:0], 3'b000} +: 8] = byte_i;
        end else if (pos_q < POS_LEN_END) begin
          if (pos_q[1:0] == 2'd0) begin
            len_d = 32'h0;
          end
          len_d[{pos_q[1:0], 3'b000} +: 8] = byte_i;
        end else if (pos_q == POS_SYM_HI) begin
          sym_bad_d = {byte_i, pend_q} != magic_q;
        end else if (pos_q == POS_CHK_LO) begin
          chk_d = {8'h00, byte_i};
        end else if (pos_q == POS_CHK_HI) begin
          chk_d = {byte_i, chk_q[7:0]};
        end else if (pos_q == POS_OFS_LO) begin
          ofs_d = {8'h00, byte_i};
        end else if (pos_q == POS_OFS_HI) begin
          ofs_d = {byte_i, ofs_q[7:0]};
        end
        sum_d  = cs_sum;
        pend_d = cs_pend;

        if (pos_q != POS_OFS_HI) begin
          if (end_i) begin
            kind    = hcmf_pkg::KIND_DISCARD;
            err     = hcmf_pkg::ERR_SHORT;
            restart = 1'b1;
          end else begin
            pos_d = pos_inc;
          end
        end else begin
          if (sym_bad_q) begin
            err = hcmf_pkg::ERR_SYMBOL;
          end else if (ofs_d < HDR_BYTES) begin
            err = hcmf_pkg::ERR_OFS_SMALL;
          end else if ({16'h0000, ofs_d} > len_q) begin
            err = hcmf_pkg::ERR_OFS_BEYOND;
          end else if ((ofs_d == HDR_BYTES) && !cs_match) begin
            err = hcmf_pkg::ERR_CHECKSUM;
          end

          if (err != hcmf_pkg::ERR_NONE) begin
            kind = hcmf_pkg::KIND_DISCARD;
            if (end_i) begin
              restart = 1'b1;
            end else begin
              phase_d = PH_DISCARD;
            end
          end else if (ofs_d == HDR_BYTES) begin
            // Header is the whole checksum range
            if (pos_inc == len_q) begin
              kind    = hcmf_pkg::KIND_LAST;
              restart = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
              pos_d   = pos_inc;
            end
          end else begin
            phase_d = PH_EXTENDED;
            pos_d   = pos_inc;
          end
        end
      end

      PH_EXTENDED: begin
        sum_d  = cs_sum;
        pend_d = cs_pend;
        if (pos_inc == {16'h0000, ofs_q}) begin
          if (!cs_match) begin
            kind = hcmf_pkg::KIND_DISCARD;
            err  = hcmf_pkg::ERR_CHECKSUM;
            if (end_i) begin
              restart = 1'b1;
            end else begin
              phase_d = PH_DISCARD;
            end
          end else if (pos_inc == len_q) begin
            kind    = hcmf_pkg::KIND_LAST;
            restart = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
            pos_d   = pos_inc;
          end
        end else begin
          pos_d = pos_inc;
        end
      end

      PH_PAYLOAD: begin
        if (pos_inc == len_q) begin
          kind    = hcmf_pkg::KIND_LAST;
          restart = 1'b1;
        end else begin
          kind  = hcmf_pkg::KIND_PAYLOAD;
          pos_d = pos_inc;
        end
      end

      default: begin
        // Drop bytes until the buffer closes
        kind = hcmf_pkg::KIND_DISCARD;
        if (end_i) begin
          restart = 1'b1;
        end
      end
    endcase

    if (restart) begin
      pos_d     = 32'h0;
      sum_d     = 16'h0;
      pend_d    = 8'h00;
      sym_bad_d = 1'b0;
      phase_d   = PH_HEADER;
    end
  end

  assign res_o.byte_out     = byte_i;
  assign res_o.kind         = kind;
  assign res_o.message_type = (kind == hcmf_pkg::KIND_LAST) ? type_q : 32'h0;
  assign res_o.error_code   = err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 32'h0;
      sum_q     <= 16'h0;
      pend_q    <= 8'h00;
      len_q     <= 32'h0;
      ofs_q     <= 16'h0;
      chk_q     <= 16'h0;
      type_q    <= 32'h0;
      phase_q   <= PH_HEADER;
      sym_bad_q <= 1'b0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      pend_q    <= pend_d;
      len_q     <= len_d;
      ofs_q     <= ofs_d;
      chk_q     <= chk_d;
      type_q    <= type_d;
      phase_q   <= phase_d;
      sym_bad_q <= sym_bad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= hcmf_pkg::MAGIC_RESET;
    end else if (cfg_we_i) begin
      magic_q <= cfg_wdata_i;
    end
  end

endmodule
